### rtl/tdpt_pkg.sv
// shared constants and types for the trial division prime tester
package tdpt_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int FIELD_BITS     = 32;
   localparam int COUNT_BITS     = 32;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // first odd trial divisor and its square
   localparam int FIRST_DIVISOR = 3;
   localparam int FIRST_SQUARE  = 9;
   localparam int DIVISOR_STEP  = 2;
   localparam int SQUARE_OFFSET = 4;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_CLASSIFY = 5'b00010,
      ST_TEST     = 5'b00100,
      ST_DIVIDE   = 5'b01000,
      ST_FINISH   = 5'b10000
   } state_type;

   // commands to the divisor generator
   typedef struct packed {
      logic init;
      logic step;
   } div_cmd_type;

   // status of the serial remainder unit
   typedef struct packed {
      logic busy;
      logic done;
      logic is_zero;
   } rem_status_type;

endpackage

### rtl/tdpt_divgen.sv
// odd trial divisor and its running square
module tdpt_divgen
   import tdpt_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  div_cmd_type           cmd,
   output logic [VALUE_BITS-1:0] divisor,
   output logic [VALUE_BITS+1:0] square
);

   logic [VALUE_BITS-1:0] d_ff, d_in;
   logic [VALUE_BITS+1:0] sq_ff, sq_in;

   // (d+2)^2 = d^2 + 4d + 4
   always_comb begin
      d_in  = d_ff;
      sq_in = sq_ff;
      if (cmd.init) begin
         d_in  = VALUE_BITS'(FIRST_DIVISOR);
         sq_in = (VALUE_BITS+2)'(FIRST_SQUARE);
      end else if (cmd.step) begin
         d_in  = d_ff + VALUE_BITS'(DIVISOR_STEP);
         sq_in = sq_ff + {d_ff, 2'b00} + (VALUE_BITS+2)'(SQUARE_OFFSET);
      end
   end

   always_ff @(posedge clock) begin
      d_ff  <= d_in;
      sq_ff <= sq_in;
   end

   assign divisor = d_ff;
   assign square  = sq_ff;

endmodule

### rtl/tdpt_rem.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
module tdpt_rem
   import tdpt_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [VALUE_BITS-1:0] divisor,
   output rem_status_type        status
);

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] shift_ff;
   logic [VALUE_BITS:0]   trial;
   logic                  fits;

   always_comb begin
      trial  = {rem_ff, shift_ff[VALUE_BITS-1]};
      fits   = trial >= {1'b0, divisor};
      rem_in = fits ? VALUE_BITS'(trial - {1'b0, divisor}) : trial[VALUE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(VALUE_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff   <= '0;
         shift_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff   <= rem_in;
         shift_ff <= shift_ff << 1;
      end
   end

   assign status.busy    = busy_ff;
   assign status.done    = done_ff;
   assign status.is_zero = (rem_ff == '0);

endmodule

### rtl/trial_division_prime_test_top.sv
// top level of the trial division prime tester
//
// Each request carries one candidate; the block answers with one response that
// holds the candidate, a prime flag and the running count of primes since the
// last request that had start_of_range set (the count saturates at all ones).
// Only the low VALUE_BITS bits of the candidate are tested. Values below two,
// two itself and even values are settled in the classify state. An odd value is
// divided by 3, 5, 7, ... while the divisor squared does not exceed it; each
// trial division passes the test state, where the square is compared, and the
// divide state, where the bit-serial remainder unit runs. One request is in
// work at a time; a finished response sits in the output register, so the next
// request is taken while the previous response still waits on rsp_stall.
module trial_division_prime_test_top
   import tdpt_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FIELD_BITS-1:0] req_candidate,
   input  logic                  req_start_of_range,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [FIELD_BITS-1:0] rsp_tested_value,
   output logic                  rsp_is_prime,
   output logic [COUNT_BITS-1:0] rsp_primes_so_far
);

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] n_ff;
   logic                  restart_ff;
   logic                  prime_ff, prime_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic                  rsp_valid_ff;
   logic [FIELD_BITS-1:0] rsp_value_ff;
   logic                  rsp_prime_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;

   div_cmd_type           div_cmd;
   logic [VALUE_BITS-1:0] divisor;
   logic [VALUE_BITS+1:0] square;
   logic                  rem_start;
   rem_status_type        rem_status;

   logic                  req_take;
   logic                  out_free;
   logic                  load_rsp;
   logic [COUNT_BITS-1:0] base_count;

   // request taken only between items
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // output slot is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = (state_ff == ST_FINISH) && out_free;

   // running count: restart first, then count this prime unless saturated
   always_comb begin
      base_count = restart_ff ? '0 : count_ff;
      count_in   = base_count;
      if (prime_ff && (base_count != COUNT_MAX)) begin
         count_in = base_count + COUNT_BITS'(1);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      prime_in     = prime_ff;
      div_cmd.init = 1'b0;
      div_cmd.step = 1'b0;
      rem_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            // below two, two, even: settled here
            if (n_ff[VALUE_BITS-1:1] == '0) begin
               prime_in = 1'b0;
               state_in = ST_FINISH;
            end else if (n_ff == VALUE_BITS'(2)) begin
               prime_in = 1'b1;
               state_in = ST_FINISH;
            end else if (!n_ff[0]) begin
               prime_in = 1'b0;
               state_in = ST_FINISH;
            end else begin
               div_cmd.init = 1'b1;
               state_in     = ST_TEST;
            end
         end
         ST_TEST: begin
            // divisor squared past the value: no factor left to find
            if (square > {2'b00, n_ff}) begin
               prime_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               rem_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (rem_status.done) begin
               if (rem_status.is_zero) begin
                  prime_in = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  div_cmd.step = 1'b1;
                  state_in     = ST_TEST;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prime_ff <= prime_in;
      if (req_take) begin
         n_ff       <= VALUE_BITS'(req_candidate);
         restart_ff <= req_start_of_range;
      end
      if (load_rsp) begin
         rsp_value_ff <= FIELD_BITS'(n_ff);
         rsp_prime_ff <= prime_ff;
         rsp_count_ff <= count_in;
      end
   end

   tdpt_divgen #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divgen (
      .clock   (clock),
      .cmd     (div_cmd),
      .divisor (divisor),
      .square  (square)
   );

   tdpt_rem #(
      .VALUE_BITS (VALUE_BITS)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (n_ff),
      .divisor  (divisor),
      .status   (rem_status)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tested_value  = rsp_value_ff;
   assign rsp_is_prime      = rsp_prime_ff;
   assign rsp_primes_so_far = rsp_count_ff;

   // a trial division only ever uses an odd divisor
   a_divisor_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> divisor[0])
      else $error("even trial divisor");

   // remainder unit reports only while the sequencer waits on it
   a_rem_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      rem_status.done |-> (state_ff == ST_DIVIDE))
      else $error("remainder done outside divide state");

   // a prime response never carries a zero count
   a_prime_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_prime_ff) |-> (rsp_count_ff != '0))
      else $error("prime response with zero count");

   // the remainder unit is never restarted mid-division
   a_rem_no_restart: assert property (@(posedge clock) disable iff (reset)
      rem_start |-> !rem_status.busy)
      else $error("remainder unit restarted while busy");

endmodule
